[src/rau_pkg.sv]
// Shared constants, types and helpers for the rational arithmetic unit.
// No dependencies; the multiplier, gcd, divider and top-level files refer to this package by scoped names.
package rau_pkg;

    // Bits of each input field that carry the operand
    localparam int OPW = 32;
    // Operand width after sign normalization (negating the most negative value grows a bit)
    localparam int NW  = OPW + 1;
    localparam int RW  = 64;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_CMP = 3'd4,
        OP_NEG = 3'd5,
        OP_REC = 3'd6
    } t_op;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_FORM = 7'b0000100,
        S_GCD  = 7'b0001000,
        S_DIVN = 7'b0010000,
        S_DIVD = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    // Take the low OPW bits of a field and sign-extend them to NW bits
    function automatic logic signed [NW-1:0] sext(input logic [31:0] v);
        logic signed [OPW-1:0] s;
        s = signed'(v[OPW-1:0]);
        return NW'(s);
    endfunction

endpackage

[src/rau_in_if.sv]
// Input channel of the rational arithmetic unit: opcode and two fractions.
// Stands alone; uses no package.
interface rau_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [31:0] a_num;
    logic [31:0] a_den;
    logic [31:0] b_num;
    logic [31:0] b_den;

    modport source (output valid, opcode, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, opcode, a_num, a_den, b_num, b_den, output ready);
endinterface

[src/rau_out_if.sv]
// Output channel of the rational arithmetic unit: reduced fraction and flags.
// Stands alone; uses no package.
interface rau_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] res_num;
    logic [62:0] res_den;
    logic        is_less;
    logic        is_equal;
    logic        is_greater;
    logic        is_undefined;
    logic        overflow;

    modport source (output valid, res_num, res_den, is_less, is_equal, is_greater,
                    is_undefined, overflow, input ready);
    modport sink   (input valid, res_num, res_den, is_less, is_equal, is_greater,
                    is_undefined, overflow, output ready);
endinterface

[src/rau_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on rau_pkg for the operand width.
module rau_mul (
    input  logic                            i_clk,
    input  logic signed [rau_pkg::NW-1:0]   i_a,
    input  logic signed [rau_pkg::NW-1:0]   i_b,
    output logic signed [2*rau_pkg::NW-1:0] o_p
);
    logic signed [2*rau_pkg::NW-1:0] r_p;

    // Register the product every cycle
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;
endmodule

[src/rau_gcd.sv]
// Binary gcd of two nonzero unsigned words, one shift or subtract per cycle.
// Depends on rau_pkg for the word width.
module rau_gcd (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [rau_pkg::RW-1:0] i_a,
    input  logic [rau_pkg::RW-1:0] i_b,
    output logic                   o_done,
    output logic [rau_pkg::RW-1:0] o_gcd
);
    logic                   r_busy, n_busy;
    logic [rau_pkg::RW-1:0] r_u, n_u, r_v, n_v;
    logic [5:0]             r_k, n_k;

    // Pick one reduction step per cycle
    always_comb begin
        n_busy = r_busy;
        n_u    = r_u;
        n_v    = r_v;
        n_k    = r_k;
        if (i_start) begin
            n_busy = 1'b1;
            n_u    = i_a;
            n_v    = i_b;
            n_k    = '0;
        end else if (r_busy) begin
            if (r_u == '0) begin
                n_busy = 1'b0;
            end else if (!r_u[0] && !r_v[0]) begin
                n_u = r_u >> 1;
                n_v = r_v >> 1;
                n_k = r_k + 6'd1;
            end else if (!r_u[0]) begin
                n_u = r_u >> 1;
            end else if (!r_v[0]) begin
                n_v = r_v >> 1;
            end else if (r_u >= r_v) begin
                n_u = (r_u - r_v) >> 1;
            end else begin
                n_v = (r_v - r_u) >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_u <= n_u;
        r_v <= n_v;
        r_k <= n_k;
    end

    assign o_done = r_busy && (r_u == '0);
    assign o_gcd  = r_v << r_k;
endmodule

[src/rau_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on rau_pkg for the word width.
module rau_div (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [rau_pkg::RW-1:0] i_dividend,
    input  logic [rau_pkg::RW-1:0] i_divisor,
    output logic                   o_done,
    output logic [rau_pkg::RW-1:0] o_quot
);
    logic                   r_busy, r_done;
    logic [5:0]             r_cnt;
    logic [rau_pkg::RW-1:0] r_rem, r_q, r_d;
    logic [rau_pkg::RW:0]   t_trial;
    logic                   t_fit;

    // Shift in the next dividend bit and try the subtract
    always_comb begin
        t_trial = {r_rem, r_q[rau_pkg::RW-1]};
        t_fit   = t_trial >= {1'b0, r_d};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_dividend;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_rem <= t_fit ? rau_pkg::RW'(t_trial - {1'b0, r_d}) : t_trial[rau_pkg::RW-1:0];
            r_q   <= {r_q[rau_pkg::RW-2:0], t_fit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

[src/rational_arithmetic_unit.sv]
// Rational arithmetic unit: add, subtract, multiply, divide, compare, negate, reciprocal.
// Undefined, compare and zero results go from the form step straight to delivery; all others
// first pass through the gcd (one shift or subtract per step) and two divider runs.
// Throughput: one item at a time; the next is taken once the result has been delivered.
// Reset: synchronous, active low; returns the sequencer to idle with no result pending.
module rational_arithmetic_unit (
    input  logic  i_clk,
    input  logic  i_rst_n,
    rau_in_if.sink    i_in,
    rau_out_if.source o_out
);
    localparam int NW = rau_pkg::NW;
    localparam int RW = rau_pkg::RW;

    rau_pkg::t_state r_state;
    logic [1:0]      r_step;

    logic [2:0]           r_op;
    logic signed [NW-1:0] r_an, r_ad, r_bn, r_bd;
    logic signed [RW-1:0] r_x, r_y, r_z;
    logic                 r_neg, r_ovf;
    logic [RW-1:0]        r_mag, r_den, r_g;
    logic [RW-1:0]        r_res_num;
    logic [RW-2:0]        r_res_den;
    logic                 r_less, r_eq, r_gt, r_undef;

    logic signed [NW-1:0] t_an, t_ad, t_bn, t_bd;
    logic signed [NW-1:0] t_ma, t_mb;
    logic signed [2*NW-1:0] t_prod;
    logic                 t_undef, t_ovf, t_neg, t_a_bad, t_b_bad;
    logic signed [RW-1:0] t_q, t_sum, t_num, t_den;
    logic [RW-1:0]        t_mag;

    logic          gcd_start, gcd_done, div_start, div_done;
    logic [RW-1:0] gcd_val, div_quot, div_dividend, div_divisor;

    // Sign-extend the operands and move each sign into the numerator
    always_comb begin
        t_an = rau_pkg::sext(i_in.a_num);
        t_ad = rau_pkg::sext(i_in.a_den);
        t_bn = rau_pkg::sext(i_in.b_num);
        t_bd = rau_pkg::sext(i_in.b_den);
        if (t_ad < 0) begin
            t_ad = -t_ad;
            t_an = -t_an;
        end
        if (t_bd < 0) begin
            t_bd = -t_bd;
            t_bn = -t_bn;
        end
    end

    // Multiplier slots: 0 numerator, 1 denominator or second cross term, 2 sum denominator
    always_comb begin
        t_ma = r_an;
        t_mb = r_bd;
        case (r_step)
            2'd0: begin
                case (r_op)
                    rau_pkg::OP_MUL: begin t_ma = r_an;  t_mb = r_bn;     end
                    rau_pkg::OP_NEG: begin t_ma = -r_an; t_mb = NW'(1);   end
                    rau_pkg::OP_REC: begin t_ma = r_ad;  t_mb = NW'(1);   end
                    default:         begin t_ma = r_an;  t_mb = r_bd;     end
                endcase
            end
            2'd1: begin
                case (r_op)
                    rau_pkg::OP_MUL: begin t_ma = r_ad;  t_mb = r_bd;     end
                    rau_pkg::OP_DIV: begin t_ma = r_ad;  t_mb = r_bn;     end
                    rau_pkg::OP_NEG: begin t_ma = r_ad;  t_mb = NW'(1);   end
                    rau_pkg::OP_REC: begin t_ma = r_an;  t_mb = NW'(1);   end
                    default:         begin t_ma = r_bn;  t_mb = r_ad;     end
                endcase
            end
            default: begin
                t_ma = r_ad;
                t_mb = r_bd;
            end
        endcase
    end

    rau_mul u_mul (
        .i_clk (i_clk),
        .i_a   (t_ma),
        .i_b   (t_mb),
        .o_p   (t_prod)
    );

    // Apply the zero rules and form the unreduced fraction
    always_comb begin
        t_a_bad = (r_ad == '0);
        t_b_bad = (r_bd == '0);
        case (r_op) inside
            rau_pkg::OP_ADD, rau_pkg::OP_SUB, rau_pkg::OP_MUL, rau_pkg::OP_CMP:
                t_undef = t_a_bad || t_b_bad;
            rau_pkg::OP_DIV: t_undef = t_a_bad || t_b_bad || (r_bn == '0);
            rau_pkg::OP_NEG: t_undef = t_a_bad;
            rau_pkg::OP_REC: t_undef = t_a_bad || (r_an == '0);
            default:         t_undef = 1'b1;
        endcase
        t_q   = (r_op == rau_pkg::OP_SUB) ? -r_y : r_y;
        t_sum = r_x + t_q;
        t_ovf = 1'b0;
        t_num = r_x;
        t_den = r_y;
        if (r_op == rau_pkg::OP_ADD || r_op == rau_pkg::OP_SUB) begin
            t_ovf = ((r_x ^ t_sum) & (t_q ^ t_sum)) >> (RW - 1) != '0;
            t_num = t_sum;
            t_den = r_z;
        end else if (r_y < 0) begin
            t_num = -r_x;
            t_den = -r_y;
        end
        t_neg = t_num[RW-1];
        t_mag = t_neg ? RW'(-t_num) : RW'(t_num);
    end

    assign gcd_start    = (r_state == rau_pkg::S_FORM) && !t_undef
                          && (r_op != rau_pkg::OP_CMP) && (t_mag != '0);
    assign div_start    = ((r_state == rau_pkg::S_GCD) && gcd_done)
                          || ((r_state == rau_pkg::S_DIVN) && div_done);
    assign div_dividend = (r_state == rau_pkg::S_GCD) ? r_mag : r_den;
    assign div_divisor  = (r_state == rau_pkg::S_GCD) ? gcd_val : r_g;

    rau_gcd u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (gcd_start),
        .i_a     (t_mag),
        .i_b     (RW'(t_den)),
        .o_done  (gcd_done),
        .o_gcd   (gcd_val)
    );

    rau_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // Sequence: take item, three multiplies, form, gcd and two divides when needed, deliver
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rau_pkg::S_IDLE;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                rau_pkg::S_IDLE: begin
                    r_step <= '0;
                    if (i_in.valid) r_state <= rau_pkg::S_MUL;
                end
                rau_pkg::S_MUL: begin
                    r_step <= r_step + 2'd1;
                    if (r_step == 2'd3) r_state <= rau_pkg::S_FORM;
                end
                rau_pkg::S_FORM: begin
                    r_state <= gcd_start ? rau_pkg::S_GCD : rau_pkg::S_OUT;
                end
                rau_pkg::S_GCD: begin
                    if (gcd_done) r_state <= rau_pkg::S_DIVN;
                end
                rau_pkg::S_DIVN: begin
                    if (div_done) r_state <= rau_pkg::S_DIVD;
                end
                rau_pkg::S_DIVD: begin
                    if (div_done) r_state <= rau_pkg::S_OUT;
                end
                rau_pkg::S_OUT: begin
                    if (o_out.ready) r_state <= rau_pkg::S_IDLE;
                end
                default: r_state <= rau_pkg::S_IDLE;
            endcase
        end
    end

    // Hold operands, products and the result
    always_ff @(posedge i_clk) begin
        if (r_state == rau_pkg::S_IDLE) begin
            r_op <= i_in.opcode;
            r_an <= t_an;
            r_ad <= t_ad;
            r_bn <= t_bn;
            r_bd <= t_bd;
        end
        if (r_state == rau_pkg::S_MUL) begin
            case (r_step)
                2'd1:    r_x <= RW'(t_prod);
                2'd2:    r_y <= RW'(t_prod);
                2'd3:    r_z <= RW'(t_prod);
                default: r_x <= r_x;
            endcase
        end
        if (r_state == rau_pkg::S_FORM) begin
            r_neg     <= t_neg;
            r_mag     <= t_mag;
            r_den     <= RW'(t_den);
            r_ovf     <= t_ovf && !t_undef;
            r_undef   <= t_undef;
            r_less    <= 1'b0;
            r_eq      <= 1'b0;
            r_gt      <= 1'b0;
            r_res_num <= '0;
            r_res_den <= '0;
            if (!t_undef && r_op == rau_pkg::OP_CMP) begin
                r_less <= r_x < r_y;
                r_eq   <= r_x == r_y;
                r_gt   <= r_x > r_y;
            end else if (!t_undef && t_mag == '0) begin
                r_res_den <= (RW-1)'(1);
            end
        end
        if (r_state == rau_pkg::S_GCD && gcd_done) r_g <= gcd_val;
        if (r_state == rau_pkg::S_DIVN && div_done) r_mag <= div_quot;
        if (r_state == rau_pkg::S_DIVD && div_done) begin
            r_res_num <= r_neg ? -r_mag : r_mag;
            r_res_den <= div_quot[RW-2:0];
        end
    end

    assign i_in.ready         = (r_state == rau_pkg::S_IDLE);
    assign o_out.valid        = (r_state == rau_pkg::S_OUT);
    assign o_out.res_num      = r_res_num;
    assign o_out.res_den      = r_res_den;
    assign o_out.is_less      = r_less;
    assign o_out.is_equal     = r_eq;
    assign o_out.is_greater   = r_gt;
    assign o_out.is_undefined = r_undef;
    assign o_out.overflow     = r_ovf;

    // Input and output sides never open together
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input ready while a result is pending");

    // An undefined result is 0/0
    a_undef_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.is_undefined) |-> (o_out.res_num == '0 && o_out.res_den == '0))
        else $error("undefined result not 0/0");

    // At most one compare flag
    a_cmp_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> $onehot0({o_out.is_less, o_out.is_equal, o_out.is_greater}))
        else $error("more than one compare flag");

    // A delivered non-undefined, non-compare result with a nonzero numerator has a nonzero denominator
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.is_undefined && !o_out.is_less && !o_out.is_equal
         && !o_out.is_greater && o_out.res_num != '0) |-> o_out.res_den != '0)
        else $error("zero denominator on defined result");
endmodule
